>>> hw/rtl/b64e_pkg.sv
// shared types, constants and alphabet function for the base64 encoder
`default_nettype none

package b64e_pkg;

    localparam int CHAR_W    = 8;
    localparam int MAX_CHARS = 4;
    localparam int CNT_W     = 3;
    localparam int IDX_W     = 2;
    localparam int CAP_W     = 32;

    localparam logic [CHAR_W-1:0] PAD_CHAR   = 8'h3D;  // '='
    localparam logic [CHAR_W-1:0] PLUS_CHAR  = 8'h2B;  // '+'
    localparam logic [CHAR_W-1:0] SLASH_CHAR = 8'h2F;  // '/'

    // one encoded run: the characters one input word gives after capping
    typedef struct packed {
        logic [MAX_CHARS-1:0][CHAR_W-1:0] chars;
        logic [CNT_W-1:0]                 count;  // 1 to 4
        logic [MAX_CHARS-1:0]             lim;    // at_limit per character
        logic                             last;   // run closes the message
    } b64e_job_t;

    // standard alphabet
    function automatic logic [CHAR_W-1:0] b64_char(input logic [5:0] v);
        logic [CHAR_W-1:0] r;
        if (v < 6'd26) begin
            r = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            r = 8'h61 + {2'b00, v - 6'd26};
        end else if (v < 6'd62) begin
            r = 8'h30 + {2'b00, v - 6'd52};
        end else if (v == 6'd62) begin
            r = PLUS_CHAR;
        end else begin
            r = SLASH_CHAR;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/b64e_front.sv
// front end: takes input words, encodes bits, applies the output cap
`default_nettype none

module b64e_front (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wen,
    input  wire logic [b64e_pkg::CAP_W-1:0]        cfg_wdata,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [7:0]                        s_in_byte,
    input  wire logic                              s_in_last,
    output logic                                   job_valid,
    input  wire logic                              job_ready,
    output b64e_pkg::b64e_job_t                    job
);
    import b64e_pkg::*;

    localparam logic [1:0] PHASE_0 = 2'd0;
    localparam logic [1:0] PHASE_1 = 2'd1;
    localparam logic [1:0] PHASE_2 = 2'd2;

    logic [1:0]       phase_reg, phase_next;
    logic [3:0]       carry_reg, carry_next;
    logic [CAP_W-1:0] emitted_reg, emitted_next;
    logic [CAP_W-1:0] max_chars_reg, max_chars_next;

    logic [MAX_CHARS-1:0][CHAR_W-1:0] chars;
    logic [CNT_W-1:0]                 made;
    logic [CNT_W-1:0]                 n_out;
    logic [CAP_W-1:0]                 room;
    logic                             capped;
    logic                             accept;
    logic [MAX_CHARS-1:0]             lim;

    always_comb begin
        chars      = {MAX_CHARS{PAD_CHAR}};
        made       = 3'd1;
        carry_next = 4'd0;
        phase_next = PHASE_0;
        case (phase_reg)
            PHASE_1: begin
                chars[0]   = b64_char({carry_reg[1:0], s_in_byte[7:4]});
                carry_next = s_in_byte[3:0];
                phase_next = PHASE_2;
                if (s_in_last) begin
                    chars[1] = b64_char({s_in_byte[3:0], 2'b00});
                    made     = 3'd3;
                end
            end
            PHASE_2: begin
                chars[0]   = b64_char({carry_reg, s_in_byte[7:6]});
                chars[1]   = b64_char(s_in_byte[5:0]);
                made       = 3'd2;
            end
            default: begin
                // phase three never occurs; treated as group start
                chars[0]   = b64_char(s_in_byte[7:2]);
                carry_next = {2'b00, s_in_byte[1:0]};
                phase_next = PHASE_1;
                if (s_in_last) begin
                    chars[1] = b64_char({s_in_byte[1:0], 4'b0000});
                    made     = 3'd4;
                end
            end
        endcase
    end

    // cap: how many of the made characters still fit
    always_comb begin
        capped = (emitted_reg >= max_chars_reg);
        room   = max_chars_reg - emitted_reg;
        if (capped) begin
            n_out = 3'd0;
        end else if (room < {{(CAP_W-CNT_W){1'b0}}, made}) begin
            n_out = room[CNT_W-1:0];
        end else begin
            n_out = made;
        end
        for (int k = 0; k < MAX_CHARS; k++) begin
            lim[k] = !capped && (room == CAP_W'(k + 1));
        end
    end

    assign s_ready   = job_ready;
    assign accept    = s_valid && s_ready;
    assign job_valid = accept && (n_out != 3'd0);

    always_comb begin
        job.chars = chars;
        job.count = n_out;
        job.lim   = lim;
        job.last  = s_in_last;
    end

    always_comb begin
        max_chars_next = cfg_wen ? cfg_wdata : max_chars_reg;
    end

    logic [1:0]       phase_upd;
    logic [3:0]       carry_upd;

    always_comb begin
        phase_upd    = phase_reg;
        carry_upd    = carry_reg;
        emitted_next = emitted_reg;
        if (accept) begin
            if (s_in_last) begin
                phase_upd    = PHASE_0;
                carry_upd    = 4'd0;
                emitted_next = '0;
            end else begin
                phase_upd    = phase_next;
                carry_upd    = carry_next;
                emitted_next = emitted_reg + {{(CAP_W-CNT_W){1'b0}}, n_out};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PHASE_0;
            carry_reg     <= 4'd0;
            emitted_reg   <= '0;
            max_chars_reg <= '1;
        end else begin
            phase_reg     <= phase_upd;
            carry_reg     <= carry_upd;
            emitted_reg   <= emitted_next;
            max_chars_reg <= max_chars_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/b64e_queue.sv
// two-entry queue of encoded runs between front and back
`default_nettype none

module b64e_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 wr_valid,
    output logic                      wr_ready,
    input  wire b64e_pkg::b64e_job_t  wr_job,
    output logic                      rd_valid,
    input  wire logic                 rd_pop,
    output b64e_pkg::b64e_job_t       rd_job
);
    import b64e_pkg::*;

    localparam int DEPTH = 2;

    b64e_job_t  entry_reg [DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push, pop;

    assign wr_ready = (fill_reg != 2'(DEPTH));
    assign rd_valid = (fill_reg != 2'd0);
    assign rd_job   = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/b64e_back.sv
// back end: sends the characters of each run one word per cycle while m_ready does not stall the output
`default_nettype none

module b64e_back (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    job_valid,
    input  wire b64e_pkg::b64e_job_t                     job,
    output logic                                         job_pop,
    output logic                                         m_valid,
    input  wire logic                                    m_ready,
    output logic [b64e_pkg::CHAR_W-1:0]                  m_out_char,
    output logic                                         m_run_last,
    output logic                                         m_message_end,
    output logic                                         m_at_limit
);
    import b64e_pkg::*;

    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0] char_reg;
    logic              run_last_reg, msg_end_reg, at_limit_reg;
    logic              load, run_end;

    assign load    = job_valid && (!m_valid_reg || m_ready);
    assign run_end = ({1'b0, idx_reg} + 3'd1) == job.count;
    assign job_pop = load && run_end;

    always_comb begin
        idx_next = idx_reg;
        if (load) begin
            idx_next = run_end ? '0 : idx_reg + 2'd1;
        end
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            char_reg     <= job.chars[idx_reg];
            at_limit_reg <= job.lim[idx_reg];
            run_last_reg <= run_end;
            msg_end_reg  <= run_end && job.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_char    = char_reg;
    assign m_run_last    = run_last_reg;
    assign m_message_end = msg_end_reg;
    assign m_at_limit    = at_limit_reg;

endmodule

`default_nettype wire

>>> hw/rtl/base64_encoder_top.sv
// top level of the streaming base64 encoder
`default_nettype none

// streaming base64 encoder, standard alphabet with '=' padding. one message
// byte per input word (s_in_last marks the final byte), one character per
// output word. a byte gives one or two characters, the final byte up to
// four including pads. the front end encodes a byte and applies the per
// message cap (cfg_wdata via cfg_wen, reset value all ones) in the cycle it
// is accepted; a two-entry run queue decouples it from the back end, which
// sends one character per cycle, when m_ready allows, into a registered
// output. throughput is set by that output; a byte whose characters are all
// dropped by the cap still takes an input handshake but queues nothing.
// m_run_last flags the last character a byte produced, m_message_end the
// last character of a message's final byte, and m_at_limit the character
// that reaches the cap. configuration must only be written while the block
// is idle; the block itself does not enforce this.
module base64_encoder_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_wen,
    input  wire logic [31:0] cfg_wdata,
    // byte input
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_in_byte,
    input  wire logic        s_in_last,
    // character output
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_char,
    output logic             m_run_last,
    output logic             m_message_end,
    output logic             m_at_limit
);
    import b64e_pkg::*;

    // front to queue
    b64e_job_t front_job;
    logic      front_valid;
    logic      front_ready;

    // queue to back
    b64e_job_t head_job;
    logic      head_valid;
    logic      head_pop;

    // encode and cap
    b64e_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .s_in_last (s_in_last),
        .job_valid (front_valid),
        .job_ready (front_ready),
        .job       (front_job)
    );

    // short run queue, lets each side stall on its own
    b64e_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_job   (front_job),
        .rd_valid (head_valid),
        .rd_pop   (head_pop),
        .rd_job   (head_job)
    );

    // character serialiser with output register
    b64e_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .job_valid     (head_valid),
        .job           (head_job),
        .job_pop       (head_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_char    (m_out_char),
        .m_run_last    (m_run_last),
        .m_message_end (m_message_end),
        .m_at_limit    (m_at_limit)
    );

endmodule

`default_nettype wire
